// ----- rtl/pojt_pkg.sv -----
`default_nettype none

package pojt_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_DEL   = 3'd1,
        CMD_CLEAR = 3'd2,
        CMD_TICK  = 3'd3,
        CMD_GET   = 3'd4
    } cmd_t;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_IDLE   = 2'd2;

    typedef struct packed {
        cmd_t        cmd;
        logic        kind;
        logic [15:0] interval;
        logic [15:0] tag;
        logic [7:0]  slot;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot;
        logic        kind;
        logic [15:0] interval;
        logic [31:0] deadline;
        logic [15:0] tag;
        logic [6:0]  freed;
        logic        last;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/pojt_ram.sv -----
`default_nettype none

module pojt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/pojt_ctrl.sv -----
`default_nettype none

module pojt_ctrl
    import pojt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    input  wire logic out_free,
    output logic      push,
    output res_t      res
);

    typedef struct packed {
        logic        kind;
        logic [15:0] interval;
        logic [31:0] deadline;
        logic [15:0] tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_EVAL,
        S_GET,
        S_END,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SLOTS-1:0]  active_reg, active_next;
    res_t              pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;

    logic              ram_we;
    logic              ram_re;
    logic [SLOT_W-1:0] ram_waddr;
    logic [SLOT_W-1:0] ram_raddr;
    entry_t            ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t            rd_entry;

    logic              advance;
    logic              id_ok;
    logic [SLOT_W-1:0] id_idx;
    logic              due;

    function automatic res_t blank_res(input logic [1:0] status);
        res_t r;
        r        = '0;
        r.status = status;
        return r;
    endfunction

    pojt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = entry_t'(ram_rdata);
    assign id_idx    = req_reg.slot[SLOT_W-1:0];
    assign id_ok     = (req_reg.slot < 8'(SLOTS)) && active_reg[id_idx];
    assign due       = (req_reg.now >= rd_entry.deadline);
    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        res      = pend_reg;
        res.last = (state_reg == S_DONE);
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        active_next     = active_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        push            = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = idx_reg;
        ram_raddr       = idx_reg;
        ram_wdata       = '0;
        advance         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                idx_next        = '0;
                cnt_next        = '0;
                pend_valid_next = 1'b0;
                unique case (req_reg.cmd) inside
                    CMD_ADD:
                    begin
                        if (req_reg.interval == 16'd0)
                        begin
                            pend_next       = blank_res(ST_REJECT);
                            pend_valid_next = 1'b1;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    CMD_DEL:
                    begin
                        if (id_ok)
                        begin
                            active_next[id_idx] = 1'b0;
                            pend_next           = blank_res(ST_OK);
                            pend_next.slot      = req_reg.slot[5:0];
                        end
                        else
                        begin
                            pend_next = blank_res(ST_REJECT);
                        end
                        pend_valid_next = 1'b1;
                        state_next      = S_DONE;
                    end
                    CMD_CLEAR, CMD_TICK:
                    begin
                        state_next = S_SCAN;
                    end
                    CMD_GET:
                    begin
                        if (id_ok)
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = id_idx;
                            state_next = S_GET;
                        end
                        else
                        begin
                            pend_next       = blank_res(ST_REJECT);
                            pend_valid_next = 1'b1;
                            state_next      = S_DONE;
                        end
                    end
                    default:
                    begin
                        pend_next       = blank_res(ST_REJECT);
                        pend_valid_next = 1'b1;
                        state_next      = S_DONE;
                    end
                endcase
            end

            S_SCAN:
            begin
                case (req_reg.cmd)
                    CMD_ADD:
                    begin
                        if (!active_reg[idx_reg])
                        begin
                            // claim the lowest free slot
                            ram_we               = 1'b1;
                            ram_wdata.kind       = req_reg.kind;
                            ram_wdata.interval   = req_reg.interval;
                            ram_wdata.deadline   = req_reg.now + 32'(req_reg.interval);
                            ram_wdata.tag        = req_reg.tag;
                            active_next[idx_reg] = 1'b1;
                            pend_next            = blank_res(ST_OK);
                            pend_next.slot       = 6'(idx_reg);
                            pend_next.kind       = req_reg.kind;
                            pend_next.interval   = req_reg.interval;
                            pend_next.deadline   = ram_wdata.deadline;
                            pend_next.tag        = req_reg.tag;
                            pend_valid_next      = 1'b1;
                            state_next           = S_DONE;
                        end
                        else
                        begin
                            advance = 1'b1;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        if (active_reg[idx_reg])
                        begin
                            cnt_next             = cnt_reg + 1'b1;
                            active_next[idx_reg] = 1'b0;
                        end
                        advance = 1'b1;
                    end
                    CMD_TICK:
                    begin
                        if (active_reg[idx_reg])
                        begin
                            ram_re     = 1'b1;
                            state_next = S_EVAL;
                        end
                        else
                        begin
                            advance = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = S_END;
                    end
                endcase
            end

            S_EVAL:
            begin
                if (!due)
                begin
                    advance = 1'b1;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    // release the previous fire, it is not the final one
                    push               = pend_valid_reg;
                    pend_next          = blank_res(ST_OK);
                    pend_next.slot     = 6'(idx_reg);
                    pend_next.kind     = rd_entry.kind;
                    pend_next.interval = rd_entry.interval;
                    pend_next.deadline = rd_entry.deadline;
                    pend_next.tag      = rd_entry.tag;
                    pend_valid_next    = 1'b1;
                    if (rd_entry.kind)
                    begin
                        active_next[idx_reg] = 1'b0;
                    end
                    else
                    begin
                        ram_we             = 1'b1;
                        ram_wdata          = rd_entry;
                        ram_wdata.deadline = req_reg.now + 32'(rd_entry.interval);
                    end
                    advance = 1'b1;
                end
            end

            S_GET:
            begin
                pend_next          = blank_res(ST_OK);
                pend_next.slot     = req_reg.slot[5:0];
                pend_next.kind     = rd_entry.kind;
                pend_next.interval = rd_entry.interval;
                pend_next.deadline = rd_entry.deadline;
                pend_next.tag      = rd_entry.tag;
                pend_valid_next    = 1'b1;
                state_next         = S_DONE;
            end

            S_END:
            begin
                case (req_reg.cmd)
                    CMD_CLEAR:
                    begin
                        pend_next       = blank_res(ST_OK);
                        pend_next.freed = 7'(cnt_reg);
                    end
                    CMD_TICK:
                    begin
                        if (!pend_valid_reg)
                        begin
                            pend_next = blank_res(ST_IDLE);
                        end
                    end
                    default:
                    begin
                        pend_next = blank_res(ST_REJECT);
                    end
                endcase
                pend_valid_next = 1'b1;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    push            = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (advance)
        begin
            if (idx_reg == LAST_IDX)
            begin
                state_next = S_END;
            end
            else
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = S_SCAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            active_reg     <= '0;
            pend_valid_reg <= 1'b0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            pend_valid_reg <= pend_valid_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

// ----- rtl/periodic_oneshot_job_table.sv -----
// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  s_tuser: cmd; s_tdata: request fields
// m_axis    out  m_tvalid/m_tready  m_tuser: status; m_tlast: last; m_tdata: slot data
//
// One item is in work at a time. Delete, get and requests rejected in S_START go
// from S_START to S_DONE, get by way of S_GET; add and clear walk the slot table
// one entry a cycle; tick passes over a free slot in S_SCAN and takes an active
// one through S_SCAN (RAM read) and S_EVAL (compare and write back). The slot
// RAM read is registered, hence the S_EVAL state. Reset frees every slot at once
// through the active bits.
// A full output register stalls the walk at the next fired slot and at the end.
`default_nettype none

module periodic_oneshot_job_table
    import pojt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [2:0]  s_tuser,   // cmd
    input  wire logic [79:0] s_tdata,   // req_kind, req_interval, req_tag, req_slot, now_sec
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [1:0]       m_tuser,   // status
    output logic             m_tlast,
    output logic [79:0]      m_tdata    // out_slot, out_kind, out_interval, out_deadline,
                                        // out_tag, freed_count
);

    req_t req;
    res_t res;
    logic push;
    logic out_free;
    logic out_valid_reg;
    res_t out_data_reg;

    always_comb
    begin
        req.cmd      = cmd_t'(s_tuser);
        req.kind     = s_tdata[0];
        req.interval = s_tdata[16:1];
        req.tag      = s_tdata[32:17];
        req.slot     = s_tdata[40:33];
        req.now      = s_tdata[72:41];
    end

    pojt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .out_free  (out_free),
        .push      (push),
        .res       (res)
    );

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.status;
    assign m_tlast  = out_data_reg.last;
    assign m_tdata  = {2'b00, out_data_reg.freed, out_data_reg.tag, out_data_reg.deadline,
                       out_data_reg.interval, out_data_reg.kind, out_data_reg.slot};

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result pushed into a full output register");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        push && res.last |=> !push)
        else $error("result pushed after the final result of an item");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        push && !res.last |-> res.status == ST_OK)
        else $error("non-final result is not a fire");

endmodule

`default_nettype wire
